// ===== design/tcfm_pkg.sv =====
// shared constants, types and a lookup function for the threshold crossing frequency meter
package tcfm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

    localparam int NUM_W = 18;
    localparam int DEN_W = 17;
    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

    localparam logic [7:0] REG_THRESHOLD       = 8'd0;
    localparam logic [7:0] REG_SAMPLE_RATE     = 8'd1;
    localparam logic [7:0] REG_CAPTURE_LENGTH  = 8'd2;
    localparam logic [7:0] REG_TARGET_CROSSING = 8'd3;

    localparam logic [15:0] RST_THRESHOLD       = 16'd18350;
    localparam logic [15:0] RST_SAMPLE_RATE     = 16'd700;
    localparam logic [15:0] RST_CAPTURE_LENGTH  = 16'd700;
    localparam logic [7:0]  RST_TARGET_CROSSING = 8'd100;

    localparam logic [1:0] STATUS_MEASURED  = 2'd0;
    localparam logic [1:0] STATUS_NO_MEAS   = 2'd1;
    localparam logic [1:0] STATUS_SATURATED = 2'd2;

    localparam logic [9:0] FREQ_MAX = 10'd999;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_SAT,
        ST_DIGIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_load;
        logic div_step;
        logic sat_load;
        logic digit_load;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic div_last;
        logic out_free;
    } t_stat;

    function automatic logic [6:0] seg_code(input logic [3:0] digit);
        logic [6:0] code;
        case (digit)
            4'd0: code = 7'h3F;
            4'd1: code = 7'h06;
            4'd2: code = 7'h5B;
            4'd3: code = 7'h4F;
            4'd4: code = 7'h66;
            4'd5: code = 7'h6D;
            4'd6: code = 7'h7D;
            4'd7: code = 7'h07;
            4'd8: code = 7'h7F;
            4'd9: code = 7'h6F;
            default: code = 7'h3F;
        endcase
        return code;
    endfunction

endpackage

// ===== design/tcfm_ctrl.sv =====
// sequencing state machine: sample acceptance, divide, saturate, digits, result hand-off
module tcfm_ctrl
    import tcfm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid && i_stat.emit) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD:  n_state = ST_DIV;
            ST_DIV: begin
                if (i_stat.div_last) begin
                    n_state = ST_SAT;
                end
            end
            ST_SAT:   n_state = ST_DIGIT;
            ST_DIGIT: n_state = ST_OUT;
            ST_OUT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            ST_LOAD:  o_cmd.div_load   = 1'b1;
            ST_DIV:   o_cmd.div_step   = 1'b1;
            ST_SAT:   o_cmd.sat_load   = 1'b1;
            ST_DIGIT: o_cmd.digit_load = 1'b1;
            ST_OUT:   o_cmd.out_load   = i_stat.out_free;
            default: begin
                o_cmd      = '0;
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/tcfm_datapath.sv =====
// registers, crossing tracking, restoring divider, digit split and output register
module tcfm_datapath
    import tcfm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [15:0] i_adc_sample,
    input  logic        i_start_capture,
    input  logic        i_cfg_valid,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_m_tready,
    output logic        o_m_tvalid,
    output logic [31:0] o_m_tdata,
    output logic [1:0]  o_m_tuser
);

    logic [15:0] r_threshold;
    logic [15:0] r_sample_rate;
    logic [15:0] r_capture_length;
    logic [7:0]  r_target;

    logic [15:0] r_prev,  n_prev;
    logic [15:0] r_pos,   n_pos;
    logic [7:0]  r_cross, n_cross;
    logic [15:0] r_prior, n_prior;
    logic [15:0] r_period, n_period;
    logic        r_found, n_found;

    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;

    logic [9:0]  r_freq;
    logic [1:0]  r_status;
    logic [3:0]  r_hund;
    logic [6:0]  r_low;
    logic [1:0]  r_status_d;

    logic        r_ovalid;
    logic [1:0]  r_ostatus;
    logic [9:0]  r_ofreq;
    logic [6:0]  r_oseg_h;
    logic [6:0]  r_oseg_t;
    logic [6:0]  r_oseg_o;

    logic [15:0] cur;
    logic        active;
    logic [15:0] idx;
    logic [15:0] pos_inc;
    logic        end_hit;
    logic        crossing;
    logic [15:0] cross_pos;
    logic [8:0]  cross_plus;
    logic [7:0]  base_cross;
    logic [15:0] base_prior;
    logic [15:0] base_period;
    logic        base_found;

    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [NUM_W-1:0] trial;
    logic             trial_ge;
    logic [NUM_W-1:0] trial_diff;

    logic        no_meas;
    logic [15:0] prod_h;
    logic [3:0]  hund;
    logic [9:0]  hund_x100;
    logic [14:0] prod_t;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  ones_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold      <= RST_THRESHOLD;
            r_sample_rate    <= RST_SAMPLE_RATE;
            r_capture_length <= RST_CAPTURE_LENGTH;
            r_target         <= RST_TARGET_CROSSING;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_THRESHOLD:       r_threshold      <= i_cfg_data;
                REG_SAMPLE_RATE:     r_sample_rate    <= i_cfg_data;
                REG_CAPTURE_LENGTH:  r_capture_length <= i_cfg_data;
                REG_TARGET_CROSSING: r_target         <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // capture tracking
    always_comb begin
        cur        = i_adc_sample & SAMPLE_MASK;
        active     = i_start_capture || (r_pos != 16'd0);
        idx        = i_start_capture ? 16'd0 : r_pos;
        pos_inc    = idx + 16'd1;
        end_hit    = (pos_inc >= r_capture_length) || (pos_inc == 16'd0);
        crossing   = (idx != 16'd0) && (r_prev < r_threshold) && (cur > r_threshold);
        cross_pos  = idx - 16'd1;
        base_cross  = i_start_capture ? 8'd0  : r_cross;
        base_prior  = i_start_capture ? 16'd0 : r_prior;
        base_period = i_start_capture ? 16'd0 : r_period;
        base_found  = i_start_capture ? 1'b0  : r_found;
        cross_plus  = {1'b0, base_cross} + 9'd1;

        n_prev   = r_prev;
        n_pos    = r_pos;
        n_cross  = r_cross;
        n_prior  = r_prior;
        n_period = r_period;
        n_found  = r_found;
        if (i_cmd.accept && active) begin
            n_cross  = base_cross;
            n_prior  = base_prior;
            n_period = base_period;
            n_found  = base_found;
            if (crossing) begin
                if (r_target != 8'd0) begin
                    if (cross_plus == {1'b0, r_target}) begin
                        n_prior = cross_pos;
                    end else if (base_cross == r_target && !base_found) begin
                        n_period = cross_pos - base_prior;
                        n_found  = 1'b1;
                    end
                end
                if (base_cross != 8'd255) begin
                    n_cross = base_cross + 8'd1;
                end
            end
            n_prev = cur;
            n_pos  = end_hit ? 16'd0 : pos_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_pos    <= '0;
            r_cross  <= '0;
            r_prior  <= '0;
            r_period <= '0;
            r_found  <= 1'b0;
        end else begin
            r_prev   <= n_prev;
            r_pos    <= n_pos;
            r_cross  <= n_cross;
            r_prior  <= n_prior;
            r_period <= n_period;
            r_found  <= n_found;
        end
    end

    // restoring divide of (2 rate + period) by 2 period, one quotient bit a cycle
    always_comb begin
        div_num    = {1'b0, r_sample_rate, 1'b0} + {2'b00, r_period};
        div_den    = {r_period, 1'b0};
        trial      = {r_rem, r_quo[NUM_W-1]};
        trial_ge   = trial >= {1'b0, div_den};
        trial_diff = trial - {1'b0, div_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_load) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem <= '0;
            r_quo <= div_num;
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], trial_ge};
        end
    end

    // saturation and decimal split
    always_comb begin
        no_meas   = !r_found || (r_period == 16'd0);
        prod_h    = 16'(r_freq) * 16'd41;
        hund      = prod_h[15:12];
        hund_x100 = 10'(hund) * 10'd100;
        prod_t    = 15'(r_low) * 15'd205;
        tens      = prod_t[14:11];
        tens_x10  = 7'(tens) * 7'd10;
        ones_full = r_low - tens_x10;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sat_load) begin
            if (no_meas) begin
                r_freq   <= 10'd0;
                r_status <= STATUS_NO_MEAS;
            end else if (r_quo > NUM_W'(FREQ_MAX)) begin
                r_freq   <= FREQ_MAX;
                r_status <= STATUS_SATURATED;
            end else begin
                r_freq   <= r_quo[9:0];
                r_status <= STATUS_MEASURED;
            end
        end
        if (i_cmd.digit_load) begin
            r_hund     <= hund;
            r_low      <= 7'(r_freq - hund_x100);
            r_status_d <= r_status;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ostatus <= r_status_d;
            r_ofreq   <= 10'(r_hund) * 10'd100 + 10'(r_low);
            r_oseg_h  <= seg_code(r_hund);
            r_oseg_t  <= seg_code(tens);
            r_oseg_o  <= seg_code(ones_full[3:0]);
        end
    end

    always_comb begin
        o_stat.emit     = active && end_hit;
        o_stat.div_last = (r_cnt == DIV_LAST);
        o_stat.out_free = !r_ovalid || i_m_tready;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_oseg_o, r_oseg_t, r_oseg_h, r_ofreq};
    assign o_m_tuser  = r_ostatus;

endmodule

// ===== design/threshold_crossing_frequency_meter_core.sv =====
// top level of the threshold crossing frequency meter
// Samples enter on the slave stream: tdata carries the sample, tuser marks the
// first sample of a capture. Unmarked samples outside a capture are dropped.
// Each sample that does not end a capture leaves the controller idle, so such
// samples stream at one per clock while no result is being computed.
// The sample that ends a capture starts the result computation: a load step,
// the restoring divider (one quotient bit a cycle), then saturation, decimal
// split and the output load, during which tready stays low.
// The result word waits in an output register until the master side takes it;
// further samples are taken meanwhile, and only a second capture end waits for
// the register to empty before its result is loaded.
// Configuration writes go in on the cfg channel (index 0 threshold, 1 sample
// rate, 2 capture length, 3 target crossing), are always ready and are meant
// for idle periods only.
// Reset (synchronous, active low) restores the default register values, ends
// any capture and discards a pending result.
module threshold_crossing_frequency_meter_core
    import tcfm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // adc_sample
    input  logic        i_s_tuser,   // start_capture
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // frequency, seg_hundreds, seg_tens, seg_ones, pad
    output logic [1:0]  o_m_tuser,   // status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    tcfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tcfm_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_adc_sample    (i_s_tdata),
        .i_start_capture (i_s_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_m_tready      (i_m_tready),
        .o_m_tvalid      (o_m_tvalid),
        .o_m_tdata       (o_m_tdata),
        .o_m_tuser       (o_m_tuser)
    );

endmodule

// ===== test/tcfm_reading_checker.sv =====
`timescale 1ns / 100ps
// checker for the frequency meter: watches the channels, predicts each reading and compares
module tcfm_reading_checker
    import tcfm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // adc_sample
    input  logic        i_s_tuser,   // start_capture
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // frequency, seg_hundreds, seg_tens, seg_ones, pad
    input  logic [1:0]  i_m_tuser,   // status
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_pending,
    output int          o_errors
);

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] freq;
        logic [6:0] hund;
        logic [6:0] tens;
        logic [6:0] ones;
    } t_reading;

    // glyphs for digits 9 down to 0, digit 0 in the lowest bits
    localparam logic [69:0] GLYPHS = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                      7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

    logic [15:0] lvl_thr;
    logic [15:0] lvl_rate;
    logic [15:0] cap_len;
    logic [7:0]  tgt_cross;

    logic [15:0] last_level;
    logic [15:0] cap_pos;
    logic [7:0]  n_cross;
    logic [15:0] first_pos;
    logic [15:0] period_len;
    logic        period_ok;

    t_reading readings_due[$];
    int       fail_count = 0;
    logic     cap_done;
    t_reading want;
    t_reading got;

    initial o_pending = 0;
    initial o_errors = 0;

    function automatic logic [6:0] digit_glyph(input int unsigned d);
        return GLYPHS[d*7 +: 7];
    endfunction

    function automatic t_reading expected_reading();
        t_reading    r;
        int unsigned num;
        int unsigned f;
        r.status = STATUS_MEASURED;
        f = 0;
        if (!period_ok || period_len == 16'd0) begin
            r.status = STATUS_NO_MEAS;
        end else begin
            num = 2 * lvl_rate + period_len;
            f = num / (2 * period_len);
            if (f > 999) begin
                f = 999;
                r.status = STATUS_SATURATED;
            end
        end
        r.freq = f[9:0];
        r.hund = digit_glyph((f / 100) % 10);
        r.tens = digit_glyph((f / 10) % 10);
        r.ones = digit_glyph(f % 10);
        return r;
    endfunction

    task automatic meter_sample(input logic [15:0] level, input logic mark,
                                output logic done, output t_reading res);
        logic [15:0] cur;
        logic [15:0] at;
        logic        active;
        done = 1'b0;
        res = '0;
        cur = level & SAMPLE_MASK;
        active = mark || (cap_pos != 16'd0);
        if (mark) begin
            cap_pos = 16'd0;
            n_cross = 8'd0;
            first_pos = 16'd0;
            period_len = 16'd0;
            period_ok = 1'b0;
        end
        if (active) begin
            if (cap_pos != 16'd0 && last_level < lvl_thr && cur > lvl_thr) begin
                at = cap_pos - 16'd1;
                if (tgt_cross != 8'd0) begin
                    if ({1'b0, n_cross} + 9'd1 == {1'b0, tgt_cross}) begin
                        first_pos = at;
                    end else if (n_cross == tgt_cross && !period_ok) begin
                        period_len = at - first_pos;
                        period_ok = 1'b1;
                    end
                end
                if (n_cross != 8'hFF) begin
                    n_cross = n_cross + 8'd1;
                end
            end
            last_level = cur;
            cap_pos = cap_pos + 16'd1;
            if (cap_pos >= cap_len || cap_pos == 16'd0) begin
                cap_pos = 16'd0;
                done = 1'b1;
                res = expected_reading();
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("tcfm mismatch: %s got %0d expected %0d at %0t", what, got_v, want_v,
                 $time);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lvl_thr = RST_THRESHOLD;
            lvl_rate = RST_SAMPLE_RATE;
            cap_len = RST_CAPTURE_LENGTH;
            tgt_cross = RST_TARGET_CROSSING;
            last_level = 16'd0;
            cap_pos = 16'd0;
            n_cross = 8'd0;
            first_pos = 16'd0;
            period_len = 16'd0;
            period_ok = 1'b0;
            readings_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_THRESHOLD:       lvl_thr = i_cfg_data;
                    REG_SAMPLE_RATE:     lvl_rate = i_cfg_data;
                    REG_CAPTURE_LENGTH:  cap_len = i_cfg_data;
                    REG_TARGET_CROSSING: tgt_cross = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.status = i_m_tuser;
                got.freq = i_m_tdata[9:0];
                got.hund = i_m_tdata[16:10];
                got.tens = i_m_tdata[23:17];
                got.ones = i_m_tdata[30:24];
                if (readings_due.size() == 0) begin
                    report_mismatch("reading with none due, frequency", got.freq, 0);
                end else begin
                    want = readings_due.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.freq !== want.freq)
                        report_mismatch("frequency", got.freq, want.freq);
                    if (got.hund !== want.hund)
                        report_mismatch("seg_hundreds", got.hund, want.hund);
                    if (got.tens !== want.tens)
                        report_mismatch("seg_tens", got.tens, want.tens);
                    if (got.ones !== want.ones)
                        report_mismatch("seg_ones", got.ones, want.ones);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                meter_sample(i_s_tdata, i_s_tuser, cap_done, want);
                if (cap_done) begin
                    readings_due.push_back(want);
                end
            end
        end
        o_pending <= readings_due.size();
        o_errors <= fail_count;
    end

endmodule

// ===== test/tb_threshold_crossing_frequency_meter_core.sv =====
`timescale 1ns / 100ps
// testbench top for the frequency meter core: stimulus, output stalls and verdict
module tb_threshold_crossing_frequency_meter_core
    import tcfm_pkg::*;
();

    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'd0;
    logic [15:0] cfg_data = 16'd0;

    int pending;
    int errors;
    int idle_cycles = 0;
    int n_items = 0;
    int n_results = 0;
    bit no_idle = 1'b0;
    bit rx_hold_req = 1'b0;

    int cur_thr = 18350;
    int cur_rate = 700;
    int cur_clen = 700;
    int cur_target = 100;

    always #5 clk = ~clk;

    threshold_crossing_frequency_meter_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    tcfm_reading_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    always @(posedge clk) begin
        if (m_tvalid && m_tready) begin
            n_results <= n_results + 1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("tb_threshold_crossing_frequency_meter_core: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side
    initial begin
        int gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 10);
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end else if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_word(input logic [15:0] level, input logic mark);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= level;
        s_tuser <= mark;
        do @(posedge clk); while (!s_tready);
    endtask

    // stop offering samples until every reading due has been taken
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[15:0];
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_meter(input int thr, input int rate, input int clen, input int target);
        settle();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_SAMPLE_RATE, rate);
        write_reg(REG_CAPTURE_LENGTH, clen);
        write_reg(REG_TARGET_CROSSING, target);
        cfg_valid <= 1'b0;
        cur_thr = thr;
        cur_rate = rate;
        cur_clen = clen;
        cur_target = target;
    endtask

    task automatic pick_setting(input bit short_caps);
        int thr;
        int rate;
        int clen;
        int target;
        int r;
        r = $urandom_range(0, 19);
        thr = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(1, 65534);
        r = $urandom_range(0, 19);
        if (r == 0) rate = 0;
        else if (r == 1) rate = 65535;
        else if (r == 2) rate = 1;
        else if (r < 10) rate = $urandom_range(1, 65535);
        else rate = $urandom_range(1, 3000);
        r = $urandom_range(0, 24);
        if (short_caps) clen = $urandom_range(2, 4);
        else if (r < 2) clen = r;
        else if (r < 4) clen = 2;
        else clen = $urandom_range(3, 30);
        r = $urandom_range(0, 11);
        if (r == 0) target = 0;
        else if (r == 1) target = 255;
        else target = $urandom_range(1, 4);
        set_meter(thr, rate, clen, target);
    endtask

    // square wave around the threshold with some noise and an occasional restart
    task automatic play_capture();
        int          len;
        int          half;
        int          k;
        int          r;
        int          lo;
        int          hi;
        bit          restarted;
        logic        mark;
        logic [15:0] v;
        len = (cur_clen < 2) ? 1 : cur_clen;
        half = $urandom_range(1, 4);
        lo = (cur_thr == 0) ? 0 : $urandom_range(0, cur_thr - 1);
        hi = (cur_thr == 65535) ? 65535 : $urandom_range(cur_thr + 1, 65535);
        k = 0;
        restarted = 1'b0;
        while (k < len) begin
            mark = (k == 0);
            if (k > 0 && !restarted && $urandom_range(0, 49) == 0) begin
                mark = 1'b1;
                restarted = 1'b1;
                k = 0;
            end
            r = $urandom_range(0, 99);
            if (r < 8) v = 16'($urandom);
            else if (r < 11) v = 16'(cur_thr);
            else v = ((k / half) % 2) ? 16'(hi) : 16'(lo);
            send_word(v, mark);
            n_items++;
            k++;
        end
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) begin
            send_word(16'($urandom), 1'b0);
        end
    endtask

    initial begin
        int phase;
        int k;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unmarked samples with no capture running are dropped
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b0);

        // sample equal to the threshold is not a crossing
        set_meter(100, 1000, 6, 1);
        send_word(16'h0000, 1'b1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'd100, 1'b0);
        send_word(16'd200, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b0);

        // restart part way through a capture
        send_word(16'h0000, 1'b1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b0);

        // one-sample captures, with a zero target and then the largest target
        set_meter(0, 65535, 1, 0);
        send_word(16'hFFFF, 1'b1);
        set_meter(65535, 0, 0, 255);
        send_word(16'h0000, 1'b1);

        // overflow, then zero rate
        set_meter(32768, 65535, 4, 1);
        send_word(16'h0000, 1'b1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        set_meter(32768, 0, 4, 1);
        send_word(16'h0000, 1'b1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b0);

        phase = 0;
        while (n_items < 120 || n_results < 20 || phase < 3) begin
            pick_setting(phase == 2);
            no_idle = ($urandom_range(0, 4) == 0);
            if (phase == 2) rx_hold_req = 1'b1;
            repeat ($urandom_range(3, 8)) begin
                play_capture();
                if ($urandom_range(0, 9) == 0) settle();
            end
            phase++;
        end

        // long capture, count saturating past the largest target
        set_meter(32768, 1000, 514, 255);
        no_idle = 1'b1;
        for (k = 0; k < 514; k++) begin
            send_word(k[0] ? 16'hFFFF : 16'h0000, k == 0);
        end
        no_idle = 1'b0;
        settle();

        if (errors == 0) begin
            $display("tb_threshold_crossing_frequency_meter_core: PASS");
        end else begin
            $display("tb_threshold_crossing_frequency_meter_core: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/tcfm_pkg.sv
design/tcfm_ctrl.sv
design/tcfm_datapath.sv
design/threshold_crossing_frequency_meter_core.sv
test/tcfm_reading_checker.sv
test/tb_threshold_crossing_frequency_meter_core.sv
